// File: sv/crcfr_pkg.sv
// Shared types and constants for the CRC-checked frame receiver.
package crcfr_pkg;

    localparam int unsigned BYTE_W = 8;
    localparam int unsigned WORD_W = 32;
    localparam int unsigned HCNT_W = 3;

    localparam logic [WORD_W-1:0] CRC_POLY = 32'hEDB8_8320;
    localparam logic [HCNT_W-1:0] HDR_LAST = 3'd3;

    typedef logic [BYTE_W-1:0] t_byte;
    typedef logic [WORD_W-1:0] t_word;
    typedef logic [HCNT_W-1:0] t_hcnt;

    typedef enum logic [1:0] {
        PH_CRC = 2'd0,
        PH_LEN = 2'd1,
        PH_PAY = 2'd2
    } t_phase;

endpackage

// File: sv/crcfr_if.sv
// Valid/ready channel interfaces for the receive byte stream and the result stream.
interface crcfr_in_if;
    import crcfr_pkg::*;

    logic  valid;
    logic  ready;
    t_byte rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface crcfr_out_if;
    import crcfr_pkg::*;

    logic  valid;
    logic  ready;
    logic  payload_valid;
    t_byte payload_byte;
    logic  frame_end;
    logic  crc_match;

    modport source (output valid, output payload_valid, output payload_byte,
                    output frame_end, output crc_match, input ready);
    modport sink   (input valid, input payload_valid, input payload_byte,
                    input frame_end, input crc_match, output ready);
endinterface

// File: sv/crc_framed_receiver.sv
// Top level of the CRC-checked, length-prefixed frame receiver.
//
// Input channel i_rx carries the stream one byte per word. Each frame is a
// 4-byte CRC, then a 4-byte length (both least significant byte first), then
// that many payload bytes. Every accepted byte produces exactly one word on
// o_res: payload bytes come out with payload_valid set, header bytes come out
// as all-zero words. The word that completes a frame has frame_end set, and
// crc_match tells whether the reflected CRC-32 (initial 0, no final xor) over
// the payload equals the header CRC. A zero length ends the frame on the last
// length byte.
// The result word is registered and appears in the cycle after its byte is
// accepted; throughput is one byte per cycle while the sink takes each word, set
// by the single result register with the byte-wide CRC network in front of it.
// Reset clears the frame state, so the block expects a fresh CRC header and
// the result register is empty. When the sink stalls, the result register
// holds its word and i_rx.ready drops until that word is taken.
module crc_framed_receiver (
    input  logic             i_clk,
    input  logic             i_rst_n,
    crcfr_in_if.sink         i_rx,
    crcfr_out_if.source      o_res
);
    import crcfr_pkg::*;

    t_phase r_phase, n_phase;
    t_hcnt  r_hcnt,  n_hcnt;
    t_word  r_exp,   n_exp;
    t_word  r_rem,   n_rem;
    t_word  r_crc,   n_crc;

    logic   r_out_valid;
    logic   r_pvalid, n_pvalid;
    t_byte  r_pbyte,  n_pbyte;
    logic   r_fend,   n_fend;
    logic   r_match,  n_match;

    t_word  crc_next;
    t_hcnt  hcnt_eff;
    logic   in_acc;

    assign i_rx.ready = !r_out_valid || o_res.ready;
    assign in_acc     = i_rx.valid && i_rx.ready;

    crcfr_crc_byte u_crc (
        .i_crc  (r_crc),
        .i_data (i_rx.rx_byte),
        .o_crc  (crc_next)
    );

    always_comb begin
        n_phase  = r_phase;
        n_hcnt   = r_hcnt;
        n_exp    = r_exp;
        n_rem    = r_rem;
        n_crc    = r_crc;
        n_pvalid = 1'b0;
        n_pbyte  = '0;
        n_fend   = 1'b0;
        n_match  = 1'b0;
        hcnt_eff = r_hcnt;
        case (r_phase)
            PH_PAY: begin
                n_pvalid = 1'b1;
                n_pbyte  = i_rx.rx_byte;
                n_crc    = crc_next;
                n_rem    = r_rem - 1'b1;
                if (r_rem == t_word'(1)) begin
                    n_fend  = 1'b1;
                    n_match = (crc_next == r_exp);
                    n_phase = PH_CRC;
                    n_hcnt  = '0;
                end
            end
            PH_LEN: begin
                n_rem = {i_rx.rx_byte, r_rem[WORD_W-1:BYTE_W]};
                if (r_hcnt >= HDR_LAST) begin
                    n_hcnt = '0;
                    n_crc  = '0;
                    if (n_rem == '0) begin
                        n_fend  = 1'b1;
                        n_match = (r_exp == '0);
                        n_phase = PH_CRC;
                    end else begin
                        n_phase = PH_PAY;
                    end
                end else begin
                    n_hcnt = r_hcnt + 1'b1;
                end
            end
            default: begin
                // An unused phase code restarts a CRC header from its first byte.
                if (r_phase != PH_CRC) begin
                    hcnt_eff = '0;
                end
                n_phase = PH_CRC;
                n_exp   = {i_rx.rx_byte, r_exp[WORD_W-1:BYTE_W]};
                if (hcnt_eff >= HDR_LAST) begin
                    n_hcnt  = '0;
                    n_phase = PH_LEN;
                end else begin
                    n_hcnt = hcnt_eff + 1'b1;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_CRC;
            r_hcnt  <= '0;
            r_exp   <= '0;
            r_rem   <= '0;
            r_crc   <= '0;
        end else if (in_acc) begin
            r_phase <= n_phase;
            r_hcnt  <= n_hcnt;
            r_exp   <= n_exp;
            r_rem   <= n_rem;
            r_crc   <= n_crc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_rx.ready) begin
            r_out_valid <= in_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_pvalid <= n_pvalid;
            r_pbyte  <= n_pbyte;
            r_fend   <= n_fend;
            r_match  <= n_match;
        end
    end

    assign o_res.valid         = r_out_valid;
    assign o_res.payload_valid = r_pvalid;
    assign o_res.payload_byte  = r_pbyte;
    assign o_res.frame_end     = r_fend;
    assign o_res.crc_match     = r_match;

    // The payload phase is only entered with a nonzero count and left when it reaches one.
    a_pay_rem_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_PAY) |-> (r_rem != '0))
        else $error("payload phase with zero bytes remaining");

    a_hcnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hcnt <= HDR_LAST)
        else $error("header byte count out of range");

    a_match_only_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_fend) |-> !r_match)
        else $error("crc_match set on a word that does not end a frame");

    a_last_byte_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && r_phase == PH_PAY && r_rem == t_word'(1))
            |=> (r_phase == PH_CRC && r_hcnt == '0 && r_fend))
        else $error("last payload byte did not close the frame");

endmodule

// File: sv/crcfr_crc_byte.sv
// Byte-wide reflected CRC-32 update: eight bit steps flattened into one XOR network.
module crcfr_crc_byte (
    input  crcfr_pkg::t_word i_crc,
    input  crcfr_pkg::t_byte i_data,
    output crcfr_pkg::t_word o_crc
);
    import crcfr_pkg::*;

    always_comb begin
        t_word c;
        c = i_crc ^ {{(WORD_W-BYTE_W){1'b0}}, i_data};
        for (int k = 0; k < BYTE_W; k++) begin
            c = (c >> 1) ^ (c[0] ? CRC_POLY : '0);
        end
        o_crc = c;
    end

endmodule
